FILE: rtl/core/fpla_pkg.sv
// Shared types, widths and codes of the flight phase landing alarm.
package fpla_pkg;

  localparam int ALT_W   = 23;
  localparam int MEAN_W  = 22;
  localparam int MS_W    = 16;
  localparam int PHASE_W = 2;
  localparam int THR_W   = 22;

  localparam int WINDOW_DEF = 10;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  // Word kinds on the input channel.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Flight phase codes.
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_FLYING = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LANDED = 2'd2;

  // Configuration register map.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_OFF = 3'd4;

  localparam logic [THR_W-1:0] TAKEOFF_RST  = 22'd5000;
  localparam logic [THR_W-1:0] LANDING_RST  = 22'd3000;
  localparam logic [MS_W-1:0]  DELAY_RST    = 16'd3000;
  localparam logic [MS_W-1:0]  TONE_ON_RST  = 16'd300;
  localparam logic [MS_W-1:0]  TONE_OFF_RST = 16'd200;

  // Queue between the filter front and the phase back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic              kind;
    logic [MEAN_W-1:0] mean;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0] takeoff_threshold_cm;
    logic [THR_W-1:0] landing_threshold_cm;
    logic [MS_W-1:0]  alarm_delay_ms;
    logic [MS_W-1:0]  tone_on_ms;
    logic [MS_W-1:0]  tone_off_ms;
  } cfg_t;

endpackage

FILE: rtl/core/fpla_if.sv
// Valid/ready channel interfaces for the input and result words.
interface fpla_in_if;
  import fpla_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [ALT_W-1:0] altitude_cm;

  modport source (output valid, output kind, output altitude_cm, input ready);
  modport sink (input valid, input kind, input altitude_cm, output ready);
endinterface

interface fpla_out_if;
  import fpla_pkg::*;

  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  filtered_altitude_cm;
  logic [PHASE_W-1:0] flight_phase;
  logic               alarm_started;
  logic               tone_on;

  modport source (output valid, output filtered_altitude_cm, output flight_phase,
                  output alarm_started, output tone_on, input ready);
  modport sink (input valid, input filtered_altitude_cm, input flight_phase,
                input alarm_started, input tone_on, output ready);
endinterface

FILE: rtl/core/flight_phase_landing_alarm.sv
// Top level: flight phase detector with landing alarm and register port.
// Path: front pipeline, queue, back result register. Throughput: one word per cycle
// while results are taken; the back takes one word per cycle from the queue unless
// its result is held, and the front stalls only when the four-entry queue is full.
// Reset: synchronous, active low; it restores register defaults, clears the
// ring valid bits at once (no clearing pass) and empties all pipeline stages.
module flight_phase_landing_alarm #(
  parameter int WINDOW = fpla_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fpla_in_if.sink                         in_ch,
  fpla_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fpla_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fpla_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fpla_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import fpla_pkg::*;

  // Configuration registers. The user must write only while the block is idle;
  // this is not enforced, and the back reads them directly without any shadowing.
  cfg_t                 cfg_r;
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  // Link between the front, the queue and the back.
  logic  push_vld;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  pop_vld;
  item_t pop_item;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.takeoff_threshold_cm <= TAKEOFF_RST;
      cfg_r.landing_threshold_cm <= LANDING_RST;
      cfg_r.alarm_delay_ms       <= DELAY_RST;
      cfg_r.tone_on_ms           <= TONE_ON_RST;
      cfg_r.tone_off_ms          <= TONE_OFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TAKEOFF:  cfg_r.takeoff_threshold_cm <= cfg_pwdata[THR_W-1:0];
        REG_LANDING:  cfg_r.landing_threshold_cm <= cfg_pwdata[THR_W-1:0];
        REG_DELAY:    cfg_r.alarm_delay_ms       <= cfg_pwdata[MS_W-1:0];
        REG_TONE_ON:  cfg_r.tone_on_ms           <= cfg_pwdata[MS_W-1:0];
        REG_TONE_OFF: cfg_r.tone_off_ms          <= cfg_pwdata[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data follows the address; unmapped addresses read as zero.
  always_comb begin
    unique case (cfg_idx)
      REG_TAKEOFF:  cfg_prdata = CFG_DATA_W'(cfg_r.takeoff_threshold_cm);
      REG_LANDING:  cfg_prdata = CFG_DATA_W'(cfg_r.landing_threshold_cm);
      REG_DELAY:    cfg_prdata = CFG_DATA_W'(cfg_r.alarm_delay_ms);
      REG_TONE_ON:  cfg_prdata = CFG_DATA_W'(cfg_r.tone_on_ms);
      REG_TONE_OFF: cfg_prdata = CFG_DATA_W'(cfg_r.tone_off_ms);
      default:      cfg_prdata = '0;
    endcase
  end

  // The front keeps the sample ring and the running sum, and turns each accepted
  // word into a classified queue entry; a sample's entry carries the clamped mean.
  fpla_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_vld  (push_vld),
    .push_item (push_item),
    .push_full (q_full)
  );

  // The queue lets the front keep filtering while the result side stalls.
  fpla_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_vld   (pop_vld),
    .pop_item  (pop_item)
  );

  // The back runs the phase machine, the landing timer and the tone, one word per
  // cycle unless the result word is stalled, and holds the result word until it is taken.
  fpla_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .pop_vld  (pop_vld),
    .pop_item (pop_item),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

FILE: rtl/core/fpla_front.sv
// Front part: sample ring, running sum and window mean pipeline.
module fpla_front #(
  parameter int WINDOW = fpla_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  fpla_in_if.sink         in_ch,
  output logic            push_vld,
  output fpla_pkg::item_t push_item,
  input  logic            push_full
);
  import fpla_pkg::*;

  localparam int PW      = $clog2(WINDOW);
  localparam int SUM_W   = ALT_W + PW;
  localparam int MAG_W   = SUM_W - 1;
  localparam int SHIFT   = MAG_W + PW;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_64);

  logic                    accept;
  logic                    take;
  logic [PW-1:0]           pos_r;
  logic [PW-1:0]           pos_nxt;
  logic [PW-1:0]           rd_addr;
  logic signed [ALT_W-1:0] ring_mem [WINDOW];
  logic signed [ALT_W-1:0] rd_data_r;
  logic                    rd_vld_r;
  logic [WINDOW-1:0]       ring_vld_r;
  logic signed [ALT_W-1:0] old_val;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  logic              s1_vld_r;
  logic              s1_kind_r;
  logic              s1_neg_r;
  logic [MAG_W-1:0]  s1_mag_r;
  logic              s2_vld_r;
  logic              s2_kind_r;
  logic              s2_neg_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic              s1_en;
  logic              s2_en;
  logic [Q_W-1:0]    quot;

  assign s2_en       = !s2_vld_r || !push_full;
  assign s1_en       = !s1_vld_r || s2_en;
  assign in_ch.ready = s1_en;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = accept && (in_ch.kind == KIND_SAMPLE);

  assign pos_nxt = (pos_r == PW'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
  // The next slot is fetched ahead, so the oldest sample is ready on arrival.
  assign rd_addr = take ? pos_nxt : pos_r;
  assign old_val = rd_vld_r ? rd_data_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(in_ch.altitude_cm);

  always_ff @(posedge clk) begin
    if (take) begin
      ring_mem[pos_r] <= in_ch.altitude_cm;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_r      <= '0;
      ring_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= ring_vld_r[rd_addr];
      if (take) begin
        pos_r             <= pos_nxt;
        sum_r             <= sum_nxt;
        ring_vld_r[pos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_r <= accept;
      end
      if (s2_en) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_kind_r <= in_ch.kind;
      s1_neg_r  <= sum_nxt[SUM_W-1];
      s1_mag_r  <= sum_nxt[MAG_W-1:0];
    end
    if (s2_en) begin
      s2_kind_r <= s1_kind_r;
      s2_neg_r  <= s1_neg_r;
      s2_prod_r <= PROD_W'(s1_mag_r) * PROD_W'(RECIP);
    end
  end

  // Division by the window length is a reciprocal multiply, exact for any non-negative sum.
  assign quot = s2_prod_r[PROD_W-1:SHIFT];

  always_comb begin
    push_item.kind = s2_kind_r;
    if (s2_neg_r) begin
      push_item.mean = '0;
    end else if (quot > Q_W'(MEAN_MAX)) begin
      push_item.mean = MEAN_MAX;
    end else begin
      push_item.mean = quot[MEAN_W-1:0];
    end
  end

  assign push_vld = s2_vld_r;

endmodule

FILE: rtl/core/fpla_queue.sv
// Short queue of classified words between front and back.
module fpla_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_vld,
  input  fpla_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_vld,
  output fpla_pkg::item_t pop_item
);
  import fpla_pkg::*;

  item_t             store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push_ok;
  logic              pop_ok;

  assign full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_vld  = (count_r != '0);
  assign push_ok  = push_vld && !full;
  assign pop_ok   = pop && pop_vld;
  assign pop_item = store[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/fpla_back.sv
// Back part: flight phase, landing timer, alarm and tone, result register.
module fpla_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fpla_pkg::cfg_t  cfg,
  input  logic            pop_vld,
  input  fpla_pkg::item_t pop_item,
  output logic            pop,
  fpla_out_if.source      out_ch
);
  import fpla_pkg::*;

  logic               take;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [MEAN_W-1:0]  mean_r;
  logic [MEAN_W-1:0]  mean_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;
  logic [MS_W-1:0]    since_r;
  logic [MS_W-1:0]    since_nxt;
  logic               alarm_r;
  logic               alarm_nxt;
  logic               tone_r;
  logic               tone_nxt;
  logic [MS_W-1:0]    timer_r;
  logic [MS_W-1:0]    timer_nxt;
  logic [MS_W-1:0]    timer_inc;
  logic [MS_W-1:0]    limit;

  assign take = pop_vld && (!out_valid_r || out_ch.ready);
  assign pop  = take;

  assign limit     = tone_r ? cfg.tone_on_ms : cfg.tone_off_ms;
  assign timer_inc = (timer_r != '1) ? timer_r + 1'b1 : timer_r;

  always_comb begin
    mean_nxt  = mean_r;
    phase_nxt = phase_r;
    since_nxt = since_r;
    alarm_nxt = alarm_r;
    tone_nxt  = tone_r;
    timer_nxt = timer_r;
    if (take) begin
      if (pop_item.kind == KIND_SAMPLE) begin
        mean_nxt = pop_item.mean;
        unique case (phase_r)
          PH_IDLE: begin
            if (pop_item.mean > cfg.takeoff_threshold_cm) begin
              phase_nxt = PH_FLYING;
            end
          end
          PH_FLYING: begin
            if (pop_item.mean < cfg.landing_threshold_cm) begin
              phase_nxt = PH_LANDED;
              since_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end else begin
        if (phase_r == PH_LANDED && !alarm_r && since_r != '1) begin
          since_nxt = since_r + 1'b1;
        end
        if (alarm_r) begin
          if (timer_inc >= limit) begin
            tone_nxt  = !tone_r;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_inc;
          end
        end
      end
      // The alarm check follows every word, so a zero delay fires on landing.
      if (phase_nxt == PH_LANDED && !alarm_r && since_nxt >= cfg.alarm_delay_ms) begin
        alarm_nxt = 1'b1;
        tone_nxt  = 1'b1;
        timer_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mean_r      <= '0;
      phase_r     <= PH_IDLE;
      since_r     <= '0;
      alarm_r     <= 1'b0;
      tone_r      <= 1'b0;
      timer_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      mean_r      <= mean_nxt;
      phase_r     <= phase_nxt;
      since_r     <= since_nxt;
      alarm_r     <= alarm_nxt;
      tone_r      <= tone_nxt;
      timer_r     <= timer_nxt;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.filtered_altitude_cm = mean_r;
  assign out_ch.flight_phase         = phase_r;
  assign out_ch.alarm_started        = alarm_r;
  assign out_ch.tone_on              = tone_r;

  a_landed_final: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LANDED |=> phase_r == PH_LANDED)
    else $error("landed phase was left");

  a_alarm_holds: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |=> alarm_r)
    else $error("alarm dropped after latching");

  a_alarm_landed: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |-> phase_r == PH_LANDED)
    else $error("alarm active outside the landed phase");

  a_tone_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    !alarm_r |-> !tone_r)
    else $error("tone on without alarm");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(phase_r) && $stable(mean_r) && $stable(tone_r))
    else $error("state moved while the result word was stalled");

endmodule

FILE: tb/flight_phase_landing_alarm_test.sv
// Testbench for the flight phase detector with landing alarm, with its own predictor.
module flight_phase_landing_alarm_test;
  import fpla_pkg::*;

  // Range of the raw altitude field that the stimulus draws from.
  localparam int ALT_LO = -100000;
  localparam int ALT_HI = 4000000;
  localparam int THR_HI = 4000000;

  // Register indexes past the end of the map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // A generous bound on the whole run, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;

  // One result word as the block reports it.
  typedef struct packed {
    logic [MEAN_W-1:0]  mean;
    logic [PHASE_W-1:0] phase;
    logic               alarm;
    logic               tone;
  } flight_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  fpla_in_if  in_ch ();
  fpla_out_if out_ch ();

  flight_phase_landing_alarm u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Free-running clock with a period of 8 time units.
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Shadow copy of the register file, starting from the reset values.
  cfg_t shadow_cfg = '{TAKEOFF_RST, LANDING_RST, DELAY_RST, TONE_ON_RST, TONE_OFF_RST};

  // Shadow copy of the block's state. The altitude ring starts out all zero,
  // which is what gives the filter its start-up lag.
  logic signed [ALT_W-1:0] alt_ring [WINDOW_DEF] = '{default: '0};
  int                      ring_wr = 0;
  longint                  alt_sum = 0;
  logic [MEAN_W-1:0]       mean_cm = '0;
  logic [PHASE_W-1:0]      phase_now = PH_IDLE;
  logic [MS_W-1:0]         landed_ms = '0;
  logic                    alarm_on = 1'b0;
  logic                    tone_now = 1'b0;
  logic [MS_W-1:0]         tone_ms = '0;

  // Result words still owed by the block, oldest first.
  flight_word_t pending_words[$];

  int  errors = 0;
  int  cycle_count = 0;
  bit  idling_on = 1'b1;
  int  hold_cycles = 0;

  // Works out the result word for one accepted input word and advances the
  // shadow state. Samples move the window mean and the phase; ticks advance the
  // landing timer and the tone timer, and after either kind the alarm may start.
  function automatic flight_word_t predict_word(input logic kind,
                                                input logic signed [ALT_W-1:0] alt);
    longint          q;
    logic [MS_W-1:0] lim;
    flight_word_t    w;
    if (kind == KIND_SAMPLE) begin
      alt_sum = alt_sum - alt_ring[ring_wr] + alt;
      alt_ring[ring_wr] = alt;
      ring_wr = (ring_wr + 1) % WINDOW_DEF;
      // Integer division truncates toward zero, then the mean is clamped.
      q = alt_sum / WINDOW_DEF;
      if (q < 0) begin
        q = 0;
      end else if (q > longint'(MEAN_MAX)) begin
        q = longint'(MEAN_MAX);
      end
      mean_cm = q[MEAN_W-1:0];
      if (phase_now == PH_IDLE) begin
        if (mean_cm > shadow_cfg.takeoff_threshold_cm) phase_now = PH_FLYING;
      end else if (phase_now == PH_FLYING) begin
        if (mean_cm < shadow_cfg.landing_threshold_cm) begin
          phase_now = PH_LANDED;
          landed_ms = '0;
        end
      end
    end else begin
      if (phase_now == PH_LANDED && !alarm_on && landed_ms != '1) landed_ms++;
      if (alarm_on) begin
        lim = tone_now ? shadow_cfg.tone_on_ms : shadow_cfg.tone_off_ms;
        if (tone_ms != '1) tone_ms++;
        // A zero tone time acts like one, since the timer is already at least one here.
        if (tone_ms >= lim) begin
          tone_now = ~tone_now;
          tone_ms = '0;
        end
      end
    end
    // The alarm check follows every word, so a tick that starts the alarm
    // leaves the tone timer at zero.
    if (phase_now == PH_LANDED && !alarm_on && landed_ms >= shadow_cfg.alarm_delay_ms) begin
      alarm_on = 1'b1;
      tone_now = 1'b1;
      tone_ms = '0;
    end
    w.mean = mean_cm;
    w.phase = phase_now;
    w.alarm = alarm_on;
    w.tone = tone_now;
    return w;
  endfunction

  function automatic logic signed [ALT_W-1:0] pick_alt(input int lo, input int hi);
    return ALT_W'(lo + int'($urandom_range(hi - lo)));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] shadow_reg(input logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_TAKEOFF:  return CFG_DATA_W'(shadow_cfg.takeoff_threshold_cm);
      REG_LANDING:  return CFG_DATA_W'(shadow_cfg.landing_threshold_cm);
      REG_DELAY:    return CFG_DATA_W'(shadow_cfg.alarm_delay_ms);
      REG_TONE_ON:  return CFG_DATA_W'(shadow_cfg.tone_on_ms);
      REG_TONE_OFF: return CFG_DATA_W'(shadow_cfg.tone_off_ms);
      default:      return '0;
    endcase
  endfunction

  // One register access: a setup phase, then an access phase that completes
  // at the rising edge where pready is high. Read data is taken at that edge.
  task automatic cfg_access(input logic [CFG_IDX_W-1:0] idx, input logic wr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Writes a register and mirrors it, masked to the register's width.
  // Indexes past the end of the map leave the shadow copy untouched.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] unused;
    cfg_access(idx, 1'b1, value, unused);
    case (idx)
      REG_TAKEOFF:  shadow_cfg.takeoff_threshold_cm = value[THR_W-1:0];
      REG_LANDING:  shadow_cfg.landing_threshold_cm = value[THR_W-1:0];
      REG_DELAY:    shadow_cfg.alarm_delay_ms = value[MS_W-1:0];
      REG_TONE_ON:  shadow_cfg.tone_on_ms = value[MS_W-1:0];
      REG_TONE_OFF: shadow_cfg.tone_off_ms = value[MS_W-1:0];
      default: ;
    endcase
  endtask

  // Reads every register back and compares it with the shadow copy.
  task automatic cfg_check_all();
    logic [CFG_DATA_W-1:0] got;
    for (int i = REG_TAKEOFF; i <= REG_TONE_OFF; i++) begin
      cfg_access(CFG_IDX_W'(i), 1'b0, '0, got);
      if (got !== shadow_reg(CFG_IDX_W'(i))) begin
        errors++;
        $display("%0t mismatch register %0d: expected %0d, actual %0d",
                 $time, i, shadow_reg(CFG_IDX_W'(i)), got);
      end
    end
  endtask

  // Offers one input word, possibly after a burst of idle cycles, and
  // records the word it must produce once the block accepts it.
  task automatic send_word(input logic kind, input logic signed [ALT_W-1:0] alt);
    int gap;
    gap = (idling_on && $urandom_range(5) == 0) ? $urandom_range(11, 1) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.altitude_cm <= alt;
    do @(posedge clk); while (!in_ch.ready);
    pending_words.push_back(predict_word(kind, alt));
  endtask

  task automatic send_random_word(input int tick_pct);
    if ($urandom_range(99) < tick_pct) begin
      send_word(KIND_TICK, pick_alt(ALT_LO, ALT_HI));
    end else begin
      send_word(KIND_SAMPLE, pick_alt(ALT_LO, ALT_HI));
    end
  endtask

  // Stops offering words and waits until every owed word has come out, then
  // a few more cycles to cover the pipeline, so that the block is idle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Reset values, masking of wide writes, writes to unused indexes, and the
  // filter while the phase is held in idle by a takeoff threshold at the top
  // of the range. A mean equal to the threshold must not start the flight.
  task automatic test_idle_filter();
    cfg_check_all();
    cfg_write(REG_TAKEOFF, 32'hFFC0_0000 | THR_HI);
    cfg_write(REG_SPARE_LO, '1);
    cfg_write(REG_SPARE_HI, 32'h0000_1234);
    cfg_check_all();
    // The first few samples show the start-up lag of the zero-filled ring.
    repeat (10) send_word(KIND_SAMPLE, ALT_W'(ALT_HI));
    send_word(KIND_TICK, ALT_W'(ALT_HI));
    repeat (10) send_word(KIND_SAMPLE, ALT_W'(ALT_LO));
    send_word(KIND_SAMPLE, '0);
    send_word(KIND_TICK, ALT_W'(ALT_LO));
    send_word(KIND_SAMPLE, ALT_W'(ALT_HI));
    repeat (110) send_random_word(30);
    wait_idle();
  endtask

  // Takeoff with a zero threshold, then a long flight that cannot end
  // because the landing threshold is also zero.
  task automatic test_takeoff_and_flight();
    cfg_write(REG_TAKEOFF, '0);
    cfg_write(REG_LANDING, '0);
    cfg_check_all();
    while (phase_now != PH_FLYING) send_word(KIND_SAMPLE, pick_alt(1, ALT_HI));
    repeat (110) send_random_word(30);
    wait_idle();
  endtask

  // Descent below a random landing threshold with the longest alarm delay,
  // some time on the ground, then a delay just ahead of the elapsed time so
  // that a tick starts the alarm.
  task automatic test_landing();
    logic [THR_W-1:0] thr;
    thr = THR_W'($urandom_range(300000, 1000));
    cfg_write(REG_DELAY, '1);
    cfg_write(REG_LANDING, 32'hFFC0_0000 | thr);
    cfg_check_all();
    while (phase_now != PH_LANDED) send_word(KIND_SAMPLE, pick_alt(ALT_LO, int'(thr) - 1));
    // Samples after landing must leave the phase alone.
    repeat ($urandom_range(40, 20)) send_random_word(75);
    wait_idle();
    cfg_write(REG_DELAY, 32'(landed_ms) + 5);
    while (!alarm_on) send_word(KIND_TICK, pick_alt(ALT_LO, ALT_HI));
    wait_idle();
  endtask

  // Tone periods under several settings, including zero, one and the top of
  // the range. The remaining registers get new values here as well; they
  // no longer change anything once the alarm runs.
  task automatic test_tone_periods();
    logic [MS_W-1:0] on_t;
    logic [MS_W-1:0] off_t;
    cfg_write(REG_DELAY, '0);
    cfg_write(REG_LANDING, THR_HI);
    cfg_write(REG_TAKEOFF, $urandom_range(THR_HI));
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin
          on_t = '0;
          off_t = '0;
        end
        1: begin
          on_t = 16'd1;
          off_t = 16'd1;
        end
        2: begin
          on_t = '1;
          off_t = '1;
        end
        default: begin
          on_t = MS_W'($urandom_range(8, 1));
          off_t = MS_W'($urandom_range(8, 1));
        end
      endcase
      cfg_write(REG_TONE_ON, 32'hABCD_0000 | on_t);
      cfg_write(REG_TONE_OFF, 32'h5432_0000 | off_t);
      cfg_check_all();
      repeat (30) send_random_word(80);
      wait_idle();
    end
  endtask

  // The receiver stops taking words for a long stretch while the sender keeps
  // offering them back to back, so the internal queue fills and the input stalls.
  task automatic test_output_stall();
    idling_on = 1'b0;
    hold_cycles = 80;
    repeat (30) send_random_word(60);
    wait_idle();
  endtask

  // A closing burst with no idle cycles on either side.
  task automatic test_full_rate();
    idling_on = 1'b0;
    repeat (60) send_random_word(50);
    wait_idle();
  endtask

  // Receiver: random stall bursts, a long hold when a test asks for one, and
  // steady readiness once idling is switched off.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(9) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(11, 1) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checker: every word taken from the block is matched with the oldest word owed.
  always @(posedge clk) begin
    flight_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t mismatch: word with none owed, actual mean %0d phase %0d",
                 $time, out_ch.filtered_altitude_cm, out_ch.flight_phase);
      end else begin
        want = pending_words.pop_front();
        if (out_ch.filtered_altitude_cm !== want.mean) begin
          errors++;
          $display("%0t mismatch filtered_altitude_cm: expected %0d, actual %0d",
                   $time, want.mean, out_ch.filtered_altitude_cm);
        end
        if (out_ch.flight_phase !== want.phase) begin
          errors++;
          $display("%0t mismatch flight_phase: expected %0d, actual %0d",
                   $time, want.phase, out_ch.flight_phase);
        end
        if (out_ch.alarm_started !== want.alarm) begin
          errors++;
          $display("%0t mismatch alarm_started: expected %0d, actual %0d",
                   $time, want.alarm, out_ch.alarm_started);
        end
        if (out_ch.tone_on !== want.tone) begin
          errors++;
          $display("%0t mismatch tone_on: expected %0d, actual %0d",
                   $time, want.tone, out_ch.tone_on);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Test sequence. The landed phase is final and reset happens only once,
  // so the tests follow the flight from the ground to the alarm.
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SAMPLE;
    in_ch.altitude_cm = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_filter();
    test_takeoff_and_flight();
    test_landing();
    test_tone_periods();
    test_output_stall();
    test_full_rate();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fpla_pkg.sv
rtl/core/fpla_if.sv
rtl/core/fpla_front.sv
rtl/core/fpla_queue.sv
rtl/core/fpla_back.sv
rtl/core/flight_phase_landing_alarm.sv
tb/flight_phase_landing_alarm_test.sv
